/* sv/lsta_pkg.sv */
package lsta_pkg;

  // Tree sizing
  localparam int MAX_LEAVES = 1024;
  localparam int TREE_NODES = 4096;
  localparam int LEAF_CAP   = (MAX_LEAVES < TREE_NODES / 4) ? MAX_LEAVES : TREE_NODES / 4;

  // Widths
  localparam int POS_W      = 11;
  localparam int LEN_W      = POS_W;
  localparam int NODE_W     = $clog2(TREE_NODES);
  localparam int DATA_W     = 64;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 63;
  localparam int MUL_CNT_W  = $clog2(LEN_W);
  localparam int ROOT_STEPS = DATA_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int STK_DEPTH  = 16;
  localparam int SP_W       = $clog2(STK_DEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_ROOT = 2'd2,
    CMD_SUM  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_FRESH      = 2'd0,
    PH_LEFT_DONE  = 2'd1,
    PH_RIGHT_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0]  l;
    logic [POS_W-1:0]  r;
    logic [NODE_W-1:0] o;
    phase_t            ph;
  } frame_t;

  typedef struct packed {
    logic [DATA_W-1:0] tot;
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] mn;
    logic [DATA_W-1:0] pd;
  } node_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_SQ_BIG,
    S_SQ_SMALL,
    S_MUL_W,
    S_APPLY,
    S_PD_RD,
    S_PD_LAT,
    S_PD_MUL,
    S_PD_WR,
    S_PD_CLR,
    S_DESC,
    S_CONT,
    S_PU_RDA,
    S_PU_RDB,
    S_PU_CALC,
    S_RET,
    S_EMIT
  } state_t;

endpackage

/* sv/lsta_mul.sv */
module lsta_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lsta_pkg::LEN_W-1:0]  len,
  input  logic [lsta_pkg::DATA_W-1:0] opnd,
  output logic                        done,
  output logic [lsta_pkg::DATA_W-1:0] prod
);
  import lsta_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]    a_r;
  logic [LEN_W-1:0]     b_r;
  logic [DATA_W-1:0]    acc_r;
  logic                 last;

  assign last = (cnt_r == MUL_CNT_W'(LEN_W - 1));

  // Step counter, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Shift-add product, modulo 2^64
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= opnd;
      b_r   <= len;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[DATA_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[LEN_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* sv/lsta_isqrt.sv */
module lsta_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lsta_pkg::DATA_W-1:0] x,
  output logic                        done,
  output logic [lsta_pkg::DATA_W-1:0] root
);
  import lsta_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]     x_r;
  logic [DATA_W-1:0]     r_r;
  logic [DATA_W-1:0]     bit_r;
  logic [DATA_W-1:0]     trial;
  logic                  last;

  assign last  = (cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1));
  assign trial = r_r + bit_r;

  // Step counter, one result bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Restoring digit-by-digit floor root
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      r_r   <= '0;
      bit_r <= {2'b01, {(DATA_W-2){1'b0}}};
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= {1'b0, r_r[DATA_W-1:1]} + bit_r;
      end else begin
        r_r <= {1'b0, r_r[DATA_W-1:1]};
      end
      bit_r <= {2'b00, bit_r[DATA_W-1:2]};
    end
  end

  assign done = done_r;
  assign root = r_r;

endmodule

/* sv/lazy_segment_tree_add_sqrt_sum_unit.sv */
// Lazy segment tree over up to 1024 unsigned 64-bit values with load, range add, range floor
// square root and range sum. One transaction is taken at a time; in_ready drops after each
// accept and returns when the walk is finished (a sum result is first placed in the output
// register). The walk visits tree nodes one by one out of a single-port node memory: a node
// is read and tested, a pending add push-down runs two shift-add multiplies plus reads and
// writes, a pull-up reads both children and writes the parent, a covered add runs one
// shift-add multiply and a covered root test runs the bit-serial square-root unit once or
// twice. The time a load or a sum takes depends on the pending adds met on the way, and a
// root over a span whose values all differ descends to every leaf. After reset and after
// every cfg_we write the node memory is cleared, one node per cycle, which keeps in_ready
// low until all 4096 nodes are written.
module lazy_segment_tree_add_sqrt_sum_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic [lsta_pkg::POS_W-1:0]  in_range_low,
  input  logic [lsta_pkg::POS_W-1:0]  in_range_high,
  input  logic [lsta_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lsta_pkg::SUM_W-1:0]  out_range_sum,
  output logic                        out_overflow,
  input  logic                        cfg_we,
  input  logic [lsta_pkg::POS_W-1:0]  cfg_data
);
  import lsta_pkg::*;

  state_t            st_r, st_nxt;
  cmd_t              cmd_r;
  logic [POS_W-1:0]  lo_r, hi_r, n_r;
  logic [VAL_W-1:0]  val_r;
  frame_t            fr_r;
  frame_t            stk_r [STK_DEPTH];
  logic [SP_W-1:0]   sp_r;
  node_t             nd_r, ch_r;
  logic              pd_side_r;
  logic [DATA_W-1:0] dl_r, rb_r, acc_r;
  logic              ovf_r;
  logic [NODE_W-1:0] clr_cnt_r;
  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic              out_ovf_r;

  // Node memory
  node_t             mem_r [TREE_NODES];
  node_t             mem_q_r;
  logic              mem_we;
  logic [NODE_W-1:0] mem_addr;
  node_t             mem_wd;

  // Shared units
  logic              mul_start, mul_done;
  logic [LEN_W-1:0]  mul_len;
  logic [DATA_W-1:0] mul_opnd, mul_prod;
  logic              sq_start, sq_done;
  logic [DATA_W-1:0] sq_x, sq_root;

  // Frame geometry
  logic [LEN_W-1:0]  len, len_a, len_b;
  logic [POS_W-1:0]  mid;
  logic [NODE_W-1:0] o_left, o_right;
  logic              covered, is_leaf, go_left, go_right;

  // Accept-side decode
  cmd_t              in_cmd;
  logic [POS_W-1:0]  clip_lo, clip_hi, cfg_n;
  logic              do_walk;

  // Arithmetic
  logic [DATA_W-1:0] app_tot, pu_tot;
  logic              app_ovf, pu_ovf;
  logic [DATA_W-1:0] nd_diff;

  assign len     = fr_r.r - fr_r.l + 1'b1;
  assign len_b   = {1'b0, len[LEN_W-1:1]};
  assign len_a   = len - len_b;
  assign mid     = POS_W'(({1'b0, fr_r.l} + {1'b0, fr_r.r}) >> 1);
  assign o_left  = {fr_r.o[NODE_W-2:0], 1'b0};
  assign o_right = {fr_r.o[NODE_W-2:0], 1'b1};
  assign covered = (lo_r <= fr_r.l) && (fr_r.r <= hi_r);
  assign is_leaf = (fr_r.l == fr_r.r);
  assign go_left  = (lo_r <= mid);
  assign go_right = (cmd_r == CMD_LOAD) ? (lo_r > mid) : (mid < hi_r);

  assign in_cmd  = cmd_t'(in_command);
  assign clip_lo = (in_range_low == '0) ? POS_W'(1) : in_range_low;
  assign clip_hi = (in_range_high > n_r) ? n_r : in_range_high;
  assign cfg_n   = (cfg_data == '0) ? POS_W'(1) :
                   (cfg_data > POS_W'(LEAF_CAP)) ? POS_W'(LEAF_CAP) : cfg_data;

  always_comb begin
    if (in_cmd == CMD_LOAD) begin
      do_walk = (in_range_low != '0) && (in_range_low <= n_r);
    end else begin
      do_walk = (clip_lo <= clip_hi);
    end
  end

  assign app_tot = nd_r.tot + mul_prod;
  assign app_ovf = (app_tot < nd_r.tot) || app_tot[DATA_W-1];
  assign pu_tot  = ch_r.tot + mem_q_r.tot;
  assign pu_ovf  = (pu_tot < ch_r.tot) || pu_tot[DATA_W-1];
  assign nd_diff = nd_r.mx - nd_r.mn;

  // Next state
  always_comb begin
    st_nxt = st_r;
    if (cfg_we) begin
      st_nxt = S_CLEAR;
    end else begin
      unique case (st_r)
        S_CLEAR: begin
          if (clr_cnt_r == NODE_W'(TREE_NODES - 1)) st_nxt = S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) st_nxt = do_walk ? S_RD : S_RET;
        end
        S_RD: st_nxt = S_CHK;
        S_CHK: begin
          unique case (cmd_r)
            CMD_LOAD: begin
              if (is_leaf) st_nxt = S_RET;
              else st_nxt = (mem_q_r.pd != '0) ? S_PD_RD : S_DESC;
            end
            CMD_ADD: begin
              if (covered) st_nxt = S_MUL_W;
              else st_nxt = (mem_q_r.pd != '0) ? S_PD_RD : S_DESC;
            end
            CMD_ROOT: begin
              if (covered) st_nxt = S_SQ_BIG;
              else st_nxt = (mem_q_r.pd != '0) ? S_PD_RD : S_DESC;
            end
            CMD_SUM: begin
              if (covered) st_nxt = S_RET;
              else st_nxt = (mem_q_r.pd != '0) ? S_PD_RD : S_DESC;
            end
            default: st_nxt = S_RET;
          endcase
        end
        S_SQ_BIG: begin
          if (sq_done) begin
            priority if (nd_r.mx == nd_r.mn) st_nxt = S_MUL_W;
            else if (nd_diff == DATA_W'(1)) st_nxt = S_SQ_SMALL;
            else st_nxt = (nd_r.pd != '0) ? S_PD_RD : S_DESC;
          end
        end
        S_SQ_SMALL: begin
          if (sq_done) begin
            if (sq_root != rb_r) st_nxt = S_MUL_W;
            else st_nxt = (nd_r.pd != '0) ? S_PD_RD : S_DESC;
          end
        end
        S_MUL_W:   if (mul_done) st_nxt = S_APPLY;
        S_APPLY:   st_nxt = S_RET;
        S_PD_RD:   st_nxt = S_PD_LAT;
        S_PD_LAT:  st_nxt = S_PD_MUL;
        S_PD_MUL:  if (mul_done) st_nxt = S_PD_WR;
        S_PD_WR:   st_nxt = pd_side_r ? S_PD_CLR : S_PD_RD;
        S_PD_CLR:  st_nxt = S_DESC;
        S_DESC:    st_nxt = S_RD;
        S_CONT: begin
          if ((fr_r.ph == PH_LEFT_DONE) && go_right) st_nxt = S_RD;
          else st_nxt = (cmd_r == CMD_SUM) ? S_RET : S_PU_RDA;
        end
        S_PU_RDA:  st_nxt = S_PU_RDB;
        S_PU_RDB:  st_nxt = S_PU_CALC;
        S_PU_CALC: st_nxt = S_RET;
        S_RET: begin
          if (sp_r != '0) st_nxt = S_CONT;
          else st_nxt = (cmd_r == CMD_SUM) ? S_EMIT : S_IDLE;
        end
        S_EMIT:    if (!out_valid_r || out_ready) st_nxt = S_IDLE;
        default:   st_nxt = S_IDLE;
      endcase
    end
  end

  // Memory port and unit controls
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = fr_r.o;
    mem_wd    = nd_r;
    mul_start = 1'b0;
    mul_len   = len;
    mul_opnd  = DATA_W'(val_r);
    sq_start  = 1'b0;
    sq_x      = mem_q_r.mx;
    unique case (st_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
        mem_wd   = '0;
      end
      S_CHK: begin
        if (cmd_r == CMD_LOAD && is_leaf) begin
          mem_we = 1'b1;
          mem_wd = '{tot: DATA_W'(val_r), mx: DATA_W'(val_r), mn: DATA_W'(val_r), pd: '0};
        end
        mul_start = (cmd_r == CMD_ADD) && covered;
        sq_start  = (cmd_r == CMD_ROOT) && covered;
      end
      S_SQ_BIG: begin
        mul_opnd  = sq_root - nd_r.mx;
        mul_start = sq_done && (nd_r.mx == nd_r.mn);
        sq_x      = nd_r.mn;
        sq_start  = sq_done && (nd_r.mx != nd_r.mn) && (nd_diff == DATA_W'(1));
      end
      S_SQ_SMALL: begin
        mul_opnd  = rb_r - nd_r.mx;
        mul_start = sq_done && (sq_root != rb_r);
      end
      S_APPLY: begin
        mem_we = 1'b1;
        mem_wd = '{tot: app_tot, mx: nd_r.mx + dl_r, mn: nd_r.mn + dl_r, pd: nd_r.pd + dl_r};
      end
      S_PD_RD: begin
        mem_addr = pd_side_r ? o_right : o_left;
      end
      S_PD_LAT: begin
        mul_start = 1'b1;
        mul_len   = pd_side_r ? len_b : len_a;
        mul_opnd  = nd_r.pd;
      end
      S_PD_WR: begin
        mem_we   = 1'b1;
        mem_addr = pd_side_r ? o_right : o_left;
        mem_wd   = '{tot: ch_r.tot + mul_prod, mx: ch_r.mx + nd_r.pd,
                     mn: ch_r.mn + nd_r.pd, pd: ch_r.pd + nd_r.pd};
      end
      S_PD_CLR: begin
        mem_we = 1'b1;
        mem_wd = '{tot: nd_r.tot, mx: nd_r.mx, mn: nd_r.mn, pd: '0};
      end
      S_PU_RDA: mem_addr = o_left;
      S_PU_RDB: mem_addr = o_right;
      S_PU_CALC: begin
        mem_we = 1'b1;
        mem_wd = '{tot: pu_tot,
                   mx: (ch_r.mx > mem_q_r.mx) ? ch_r.mx : mem_q_r.mx,
                   mn: (ch_r.mn < mem_q_r.mn) ? ch_r.mn : mem_q_r.mn,
                   pd: '0};
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (st_r == S_IDLE) && !cfg_we;

  // Node memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wd;
    end
    mem_q_r <= mem_r[mem_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_cnt_r   <= '0;
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      n_r         <= POS_W'(LEAF_CAP);
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        n_r       <= cfg_n;
        clr_cnt_r <= '0;
        ovf_r     <= 1'b0;
      end else if (st_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (!cfg_we) begin
        if ((st_r == S_APPLY && cmd_r == CMD_ADD && app_ovf) ||
            (st_r == S_PU_CALC && pu_ovf)) begin
          ovf_r <= 1'b1;
        end
      end
      // walk stack pointer
      if (st_r == S_IDLE) begin
        sp_r <= '0;
      end else if (st_r == S_DESC ||
                   (st_r == S_CONT && st_nxt == S_RD)) begin
        sp_r <= sp_r + 1'b1;
      end else if (st_r == S_RET && sp_r != '0) begin
        sp_r <= sp_r - 1'b1;
      end
      // output register
      if (st_r == S_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        cmd_r <= in_cmd;
        lo_r  <= (in_cmd == CMD_LOAD) ? in_range_low : clip_lo;
        hi_r  <= clip_hi;
        val_r <= in_value;
        acc_r <= '0;
        fr_r  <= '{l: POS_W'(1), r: n_r, o: NODE_W'(1), ph: PH_FRESH};
      end
      S_CHK: begin
        nd_r      <= mem_q_r;
        pd_side_r <= 1'b0;
        if (cmd_r == CMD_SUM && covered) acc_r <= acc_r + mem_q_r.tot;
        if (mul_start) dl_r <= mul_opnd;
      end
      S_SQ_BIG: begin
        if (sq_done) rb_r <= sq_root;
        if (mul_start) dl_r <= mul_opnd;
      end
      S_SQ_SMALL: begin
        if (mul_start) dl_r <= mul_opnd;
      end
      S_PD_LAT: ch_r <= mem_q_r;
      S_PD_WR:  pd_side_r <= 1'b1;
      S_PU_RDB: ch_r <= mem_q_r;
      S_DESC: begin
        if (go_left) begin
          stk_r[sp_r] <= '{l: fr_r.l, r: fr_r.r, o: fr_r.o, ph: PH_LEFT_DONE};
          fr_r        <= '{l: fr_r.l, r: mid, o: o_left, ph: PH_FRESH};
        end else begin
          stk_r[sp_r] <= '{l: fr_r.l, r: fr_r.r, o: fr_r.o, ph: PH_RIGHT_DONE};
          fr_r        <= '{l: mid + 1'b1, r: fr_r.r, o: o_right, ph: PH_FRESH};
        end
      end
      S_CONT: begin
        if ((fr_r.ph == PH_LEFT_DONE) && go_right) begin
          stk_r[sp_r] <= '{l: fr_r.l, r: fr_r.r, o: fr_r.o, ph: PH_RIGHT_DONE};
          fr_r        <= '{l: mid + 1'b1, r: fr_r.r, o: o_right, ph: PH_FRESH};
        end
      end
      S_RET: begin
        if (sp_r != '0) fr_r <= stk_r[sp_r - 1'b1];
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_sum_r <= acc_r[SUM_W-1:0];
          out_ovf_r <= ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  lsta_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .len   (mul_len),
    .opnd  (mul_opnd),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lsta_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;
  assign out_overflow  = out_ovf_r;

endmodule

/* sv/lsta_chk.sv */
module lsta_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_command,
  input logic [lsta_pkg::POS_W-1:0]  in_range_low,
  input logic [lsta_pkg::POS_W-1:0]  in_range_high,
  input logic [lsta_pkg::VAL_W-1:0]  in_value,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lsta_pkg::SUM_W-1:0]  out_range_sum,
  input logic                        out_overflow,
  input logic                        cfg_we,
  input logic [lsta_pkg::POS_W-1:0]  cfg_data
);

  // Reset starts the clearing pass and empties the output
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or result after reset");

  // A register write restarts the clearing pass
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("ready right after register write");

  // One transaction in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_sum) && $stable(out_overflow))
    else $error("stalled result changed");

endmodule

bind lazy_segment_tree_add_sqrt_sum_unit lsta_chk u_lsta_chk (.*);

/* sim/lazy_segment_tree_add_sqrt_sum_unit_tb.sv */
`timescale 1ns / 100ps

module lazy_segment_tree_add_sqrt_sum_unit_tb;
  import lsta_pkg::*;

  localparam logic [63:0] SUM_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          STALL_MAX = 2000000;

  typedef struct {
    logic [SUM_W-1:0] range_sum;
    logic             overflow;
  } sum_rec_t;

  // Shadow segment tree and queue of pending sum results
  class tree_scoreboard;
    logic [63:0] tot [TREE_NODES];
    logic [63:0] mx  [TREE_NODES];
    logic [63:0] mn  [TREE_NODES];
    logic [63:0] pd  [TREE_NODES];
    bit          ovf;
    int unsigned leaves;
    sum_rec_t    sums_due[$];
    int          errors;

    function new();
      errors = 0;
      leaves = 1024;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < TREE_NODES; i++) begin
        tot[i] = '0; mx[i] = '0; mn[i] = '0; pd[i] = '0;
      end
      ovf = 0;
    endfunction

    function void set_leaves(logic [POS_W-1:0] v);
      if (v == 0) leaves = 1;
      else if (v > LEAF_CAP) leaves = LEAF_CAP;
      else leaves = v;
      wipe();
    endfunction

    // exact floor square root, one result bit per step
    function logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] r, t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function void shift_node(int unsigned o, logic [63:0] len, logic [63:0] d);
      tot[o] += len * d;
      mx[o]  += d;
      mn[o]  += d;
      pd[o]  += d;
    endfunction

    function void push(int unsigned o, logic [63:0] len);
      if (pd[o] != 0) begin
        shift_node(2 * o, len - (len >> 1), pd[o]);
        shift_node(2 * o + 1, len >> 1, pd[o]);
        pd[o] = '0;
      end
    endfunction

    function void pull(int unsigned o);
      logic [63:0] s;
      s = tot[2 * o] + tot[2 * o + 1];
      if (s < tot[2 * o] || s > SUM_MAX) ovf = 1;
      tot[o] = s;
      mx[o] = (mx[2 * o] > mx[2 * o + 1]) ? mx[2 * o] : mx[2 * o + 1];
      mn[o] = (mn[2 * o] < mn[2 * o + 1]) ? mn[2 * o] : mn[2 * o + 1];
    endfunction

    function void load_walk(int unsigned l, int unsigned r, int unsigned o,
                            int unsigned p, logic [63:0] v);
      int unsigned m;
      if (l == r) begin
        tot[o] = v; mx[o] = v; mn[o] = v; pd[o] = '0;
        return;
      end
      push(o, r - l + 1);
      m = (l + r) >> 1;
      if (p <= m) load_walk(l, m, 2 * o, p, v);
      else load_walk(m + 1, r, 2 * o + 1, p, v);
      pull(o);
    endfunction

    function void add_walk(int unsigned l, int unsigned r, int unsigned o,
                           int unsigned lo, int unsigned hi, logic [63:0] c);
      int unsigned m;
      logic [63:0] len, s;
      len = r - l + 1;
      if (lo <= l && r <= hi) begin
        s = tot[o] + c * len;
        if (s < tot[o] || s > SUM_MAX) ovf = 1;
        shift_node(o, len, c);
        return;
      end
      push(o, len);
      m = (l + r) >> 1;
      if (lo <= m) add_walk(l, m, 2 * o, lo, hi, c);
      if (m < hi) add_walk(m + 1, r, 2 * o + 1, lo, hi, c);
      pull(o);
    endfunction

    function void root_walk(int unsigned l, int unsigned r, int unsigned o,
                            int unsigned lo, int unsigned hi);
      int unsigned m;
      logic [63:0] len, rb;
      len = r - l + 1;
      if (lo <= l && r <= hi) begin
        rb = isqrt(mx[o]);
        // flat node, or two adjacent values straddling a square
        if (mx[o] == mn[o] || (mx[o] - mn[o] == 1 && rb != isqrt(mn[o]))) begin
          shift_node(o, len, rb - mx[o]);
          return;
        end
      end
      push(o, len);
      m = (l + r) >> 1;
      if (lo <= m) root_walk(l, m, 2 * o, lo, hi);
      if (m < hi) root_walk(m + 1, r, 2 * o + 1, lo, hi);
      pull(o);
    endfunction

    function logic [63:0] sum_walk(int unsigned l, int unsigned r, int unsigned o,
                                   int unsigned lo, int unsigned hi);
      int unsigned m;
      logic [63:0] acc;
      acc = '0;
      if (lo <= l && r <= hi) return tot[o];
      push(o, r - l + 1);
      m = (l + r) >> 1;
      if (lo <= m) acc += sum_walk(l, m, 2 * o, lo, hi);
      if (m < hi) acc += sum_walk(m + 1, r, 2 * o + 1, lo, hi);
      return acc;
    endfunction

    // apply one accepted input transaction to the shadow tree
    function void note_input(cmd_t cmd, logic [POS_W-1:0] lo_in, logic [POS_W-1:0] hi_in,
                             logic [VAL_W-1:0] v);
      int unsigned lo, hi;
      sum_rec_t rec;
      logic [63:0] full;
      lo = lo_in;
      hi = hi_in;
      if (cmd == CMD_LOAD) begin
        if (lo >= 1 && lo <= leaves) load_walk(1, leaves, 1, lo, {32'd0, v});
        return;
      end
      if (lo < 1) lo = 1;
      if (hi > leaves) hi = leaves;
      case (cmd)
        CMD_ADD:  if (lo <= hi) add_walk(1, leaves, 1, lo, hi, {32'd0, v});
        CMD_ROOT: if (lo <= hi) root_walk(1, leaves, 1, lo, hi);
        default: begin
          full = (lo <= hi) ? sum_walk(1, leaves, 1, lo, hi) : '0;
          rec.range_sum = full[SUM_W-1:0];
          rec.overflow  = ovf;
          sums_due = {sums_due, rec};
        end
      endcase
    endfunction

    function void check_result(logic [SUM_W-1:0] s, logic f);
      sum_rec_t e;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result sum=%0d overflow=%0b", $time, s, f);
        errors++;
        return;
      end
      e = sums_due.pop_front();
      if (s !== e.range_sum) begin
        $display("%0t: range_sum expected %0d actual %0d", $time, e.range_sum, s);
        errors++;
      end
      if (f !== e.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time, e.overflow, f);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         in_command = '0;
  logic [POS_W-1:0]   in_range_low = '0;
  logic [POS_W-1:0]   in_range_high = '0;
  logic [VAL_W-1:0]   in_value = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [SUM_W-1:0]   out_range_sum;
  logic               out_overflow;
  logic               cfg_we = 0;
  logic [POS_W-1:0]   cfg_data = '0;

  tree_scoreboard sb = new();
  bit             calm = 0;     // no idling on either side while set
  int             stall_left = 0;
  int             quiet_cycles = 0;
  int unsigned    n_now = 1024;

  lazy_segment_tree_add_sqrt_sum_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_range_low(in_range_low),
    .in_range_high(in_range_high), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_range_sum(out_range_sum), .out_overflow(out_overflow),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm) return 0;
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // result side: check, random back-pressure, watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_range_sum, out_overflow);
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("simulation failed");
      $finish;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // one input transaction; valid stays up across back-to-back items
  task automatic send(cmd_t cmd, int unsigned lo, int unsigned hi, logic [VAL_W-1:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid      <= 1;
    in_command    <= cmd;
    in_range_low  <= lo[POS_W-1:0];
    in_range_high <= hi[POS_W-1:0];
    in_value      <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, lo[POS_W-1:0], hi[POS_W-1:0], v);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.sums_due.size() != 0 || !in_ready) @(posedge clk);
  endtask

  task automatic set_leaves(logic [POS_W-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we   <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_leaves(v);
    n_now = sb.leaves;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int p;
    int unsigned k;
    p = $urandom_range(0, 99);
    k = $urandom_range(0, 65535);
    if (p < 30) return $urandom_range(0, 20);
    if (p < 50) return k * k;          // exact square
    if (p < 65) return k * k - 1;      // just under a square
    if (p < 75) return 32'hFFFF_FFFF;
    if (p < 80) return 0;
    return $urandom;
  endfunction

  task automatic random_item();
    int p;
    int unsigned lo, hi, w;
    cmd_t c;
    p = $urandom_range(0, 99);
    if (p < 8) begin
      // noise: raw positions, clipped or out-of-tree spans
      c = cmd_t'($urandom_range(0, 3));
      send(c, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom);
      return;
    end
    lo = $urandom_range(1, n_now);
    w  = (n_now <= 64) ? n_now : 16;
    hi = ($urandom_range(0, 99) < 4) ? n_now : lo + $urandom_range(0, w);
    if (hi > n_now) hi = n_now;
    if ($urandom_range(0, 9) == 0) lo = 1;
    if (p < 22) send(CMD_LOAD, lo, 0, pick_value());
    else if (p < 48) send(CMD_ADD, lo, hi, ($urandom_range(0, 3) == 0) ? pick_value()
                                                                      : $urandom_range(0, 50));
    else if (p < 72) send(CMD_ROOT, lo, hi, $urandom);
    else send(CMD_SUM, lo, hi, $urandom);
  endtask

  int leaf_plan [] = '{1, 0, 2, 3, 8, 17, 64, 2047, 1023, 5, 40};
  int per_phase;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, ignored loads, clipping, empty spans, root special cases
    send(CMD_LOAD, 1, 0, 32'hFFFF_FFFF);
    send(CMD_LOAD, 1024, 0, 32'hFFFF_FFFF);
    send(CMD_LOAD, 0, 0, 32'h1234_5678);
    send(CMD_LOAD, 1025, 0, 32'd7);
    send(CMD_LOAD, 2047, 2047, 32'd9);
    send(CMD_SUM, 0, 2047, 0);
    send(CMD_ADD, 1, 1024, 32'hFFFF_FFFF);
    send(CMD_SUM, 1, 1024, 0);
    send(CMD_LOAD, 2, 0, 32'd15);
    send(CMD_LOAD, 3, 0, 32'd16);
    send(CMD_ROOT, 2, 3, 0);
    send(CMD_SUM, 2, 3, 0);
    send(CMD_ROOT, 1, 1, 0);
    send(CMD_SUM, 1, 1, 0);
    send(CMD_ADD, 9, 4, 32'd5);
    send(CMD_ROOT, 9, 4, 0);
    send(CMD_SUM, 9, 4, 0);
    send(CMD_ADD, 500, 2047, 32'd0);
    send(CMD_SUM, 1024, 1024, 0);
    send(CMD_SUM, 1, 2, 0);

    // phases over several leaf counts
    foreach (leaf_plan[i]) begin
      set_leaves(POS_W'(leaf_plan[i]));
      calm = (i % 4 == 3);
      for (int unsigned k = 1; k <= n_now && k <= 48; k++)
        send(CMD_LOAD, (n_now <= 48) ? k : $urandom_range(1, n_now), 0, pick_value());
      per_phase = (n_now >= 1000) ? 90 : 160;
      for (int j = 0; j < per_phase; j++) begin
        random_item();
        if (i == 4 && j == 60) drain();   // sender holds off until results are in
      end
      calm = 0;
    end
    set_leaves(POS_W'($urandom_range(1, 100)));
    repeat (40) random_item();

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.sums_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
